// ===== src/tccw_pkg.sv =====
package tccw_pkg;

	// Screen geometry and tab stop
	localparam int SCREEN_WIDTH  = 80;
	localparam int SCREEN_HEIGHT = 25;
	localparam int TAB_WIDTH     = 4;

	// Field widths fixed by the ports
	localparam int ROW_W   = 5;
	localparam int COL_W   = 7;
	localparam int CHAR_W  = 8;
	localparam int COLOR_W = 8;
	localparam int MODE_W  = 2;

	localparam int TAB_CNT_W = (TAB_WIDTH > 1) ? $clog2(TAB_WIDTH) : 1;

	localparam logic [COL_W-1:0]     COL_LAST     = COL_W'(SCREEN_WIDTH - 1);
	localparam logic [ROW_W-1:0]     ROW_LAST     = ROW_W'(SCREEN_HEIGHT - 1);
	localparam logic [TAB_CNT_W-1:0] TAB_CNT_LAST = TAB_CNT_W'(TAB_WIDTH - 1);

	// Command modes
	localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
	localparam logic [MODE_W-1:0] MODE_INIT  = 2'd2;

	// Character codes
	localparam logic [CHAR_W-1:0] CH_NUL     = 8'd0;
	localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
	localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
	localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;

	localparam logic [COLOR_W-1:0] DEFAULT_COLOR = 8'd7;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PRE_CLR,
		ST_PUT_CHAR,
		ST_WRAP_CLR,
		ST_TAB,
		ST_TAB_FLUSH,
		ST_FILL
	} state_t;

	// Result of the shared cursor advance unit
	typedef struct packed {
		logic [ROW_W-1:0] row_nx;
		logic [COL_W-1:0] col_nx;
		logic             row_end;
		logic             col_end;
	} adv_t;

	// One span command
	typedef struct packed {
		logic [ROW_W-1:0]   row;
		logic [COL_W-1:0]   first_col;
		logic [COL_W-1:0]   last_col;
		logic [CHAR_W-1:0]  ch;
		logic [COLOR_W-1:0] color;
		logic               last;
	} span_t;

endpackage

// ===== src/tccw_adv.sv =====
module tccw_adv (
	input  logic [tccw_pkg::ROW_W-1:0] row_in,
	input  logic [tccw_pkg::COL_W-1:0] col_in,
	output tccw_pkg::adv_t             adv
);

	// Step column and row by one, each wrapping to zero at its limit
	always_comb begin
		adv.col_end = (col_in == tccw_pkg::COL_LAST);
		adv.row_end = (row_in == tccw_pkg::ROW_LAST);
		adv.col_nx  = adv.col_end ? '0 : col_in + 1'b1;
		adv.row_nx  = adv.row_end ? '0 : row_in + 1'b1;
	end

endmodule

// ===== src/tccw_seq.sv =====
module tccw_seq (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [tccw_pkg::MODE_W-1:0]  mode,
	input  logic [tccw_pkg::CHAR_W-1:0]  char_code,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [tccw_pkg::COLOR_W-1:0] cfg_color,
	input  logic                         ofree,
	output logic                         emit,
	output tccw_pkg::span_t              span
);

	tccw_pkg::state_t state_q, state_d;

	logic [tccw_pkg::COLOR_W-1:0]   color_q, color_d;
	logic [tccw_pkg::ROW_W-1:0]     crow_q, crow_d;
	logic [tccw_pkg::COL_W-1:0]     ccol_q, ccol_d;
	logic                           wrap_q, wrap_d;
	logic                           clr_last_q, clr_last_d;
	logic                           open_q, open_d;
	logic [tccw_pkg::TAB_CNT_W-1:0] tab_cnt_q, tab_cnt_d;
	logic [tccw_pkg::CHAR_W-1:0]    ch_q, ch_d;
	logic [tccw_pkg::ROW_W-1:0]     run_row_q, run_row_d;
	logic [tccw_pkg::COL_W-1:0]     run_first_q, run_first_d;
	logic [tccw_pkg::COL_W-1:0]     run_last_q, run_last_d;
	logic [tccw_pkg::ROW_W-1:0]     fill_row_q, fill_row_d;

	logic [tccw_pkg::ROW_W-1:0] adv_row;
	logic [tccw_pkg::ROW_W-1:0] tab_row;
	logic [tccw_pkg::COL_W-1:0] tab_first;
	logic                       step_last;
	tccw_pkg::adv_t             adv;

	// Shared advance unit, fed the cursor or the fill row counter
	tccw_adv u_adv (
		.row_in (adv_row),
		.col_in (ccol_q),
		.adv    (adv)
	);

	assign step_last = (tab_cnt_q == tccw_pkg::TAB_CNT_LAST);
	assign tab_row   = open_q ? run_row_q : crow_q;
	assign tab_first = open_q ? run_first_q : ccol_q;

	// Next state, register updates and span generation
	always_comb begin
		state_d     = state_q;
		color_d     = color_q;
		crow_d      = crow_q;
		ccol_d      = ccol_q;
		wrap_d      = wrap_q;
		clr_last_d  = clr_last_q;
		open_d      = open_q;
		tab_cnt_d   = tab_cnt_q;
		ch_d        = ch_q;
		run_row_d   = run_row_q;
		run_first_d = run_first_q;
		run_last_d  = run_last_q;
		fill_row_d  = fill_row_q;
		adv_row     = crow_q;
		emit        = 1'b0;
		span        = '0;
		in_stall    = (state_q != tccw_pkg::ST_IDLE);
		cfg_ready   = (state_q == tccw_pkg::ST_IDLE);

		unique case (state_q)
			tccw_pkg::ST_IDLE: begin
				if (cfg_valid) begin
					color_d = cfg_color;
				end
				if (in_valid) begin
					case (mode)
						tccw_pkg::MODE_PUT: begin
							if (char_code == tccw_pkg::CH_NEWLINE) begin
								ccol_d = '0;
								crow_d = adv.row_nx;
								if (adv.row_end) begin
									wrap_d     = 1'b1;
									clr_last_d = 1'b1;
									state_d    = tccw_pkg::ST_WRAP_CLR;
								end
							end else if (char_code == tccw_pkg::CH_TAB) begin
								tab_cnt_d = '0;
								open_d    = 1'b0;
								state_d   = tccw_pkg::ST_TAB;
							end else begin
								ch_d    = char_code;
								state_d = (wrap_q && !adv.col_end) ? tccw_pkg::ST_PRE_CLR
								                                   : tccw_pkg::ST_PUT_CHAR;
							end
						end
						tccw_pkg::MODE_CLEAR: begin
							fill_row_d = '0;
							state_d    = tccw_pkg::ST_FILL;
						end
						tccw_pkg::MODE_INIT: begin
							color_d    = tccw_pkg::DEFAULT_COLOR;
							crow_d     = '0;
							ccol_d     = '0;
							fill_row_d = '0;
							state_d    = tccw_pkg::ST_FILL;
						end
						default: begin
							state_d = tccw_pkg::ST_IDLE;
						end
					endcase
				end
			end

			// Blank the rest of the line once the screen has wrapped
			tccw_pkg::ST_PRE_CLR: begin
				if (ofree) begin
					emit    = 1'b1;
					span    = '{crow_q, adv.col_nx, tccw_pkg::COL_LAST,
					            tccw_pkg::CH_NUL, color_q, 1'b0};
					state_d = tccw_pkg::ST_PUT_CHAR;
				end
			end

			tccw_pkg::ST_PUT_CHAR: begin
				if (ofree) begin
					emit    = 1'b1;
					span    = '{crow_q, ccol_q, ccol_q, ch_q, color_q,
					            !(adv.col_end && adv.row_end)};
					ccol_d  = adv.col_nx;
					state_d = tccw_pkg::ST_IDLE;
					if (adv.col_end) begin
						crow_d = adv.row_nx;
						if (adv.row_end) begin
							wrap_d     = 1'b1;
							clr_last_d = 1'b1;
							state_d    = tccw_pkg::ST_WRAP_CLR;
						end
					end
				end
			end

			// Clear of row 0 after the cursor wraps off the bottom
			tccw_pkg::ST_WRAP_CLR: begin
				if (ofree) begin
					emit    = 1'b1;
					span    = '{'0, '0, tccw_pkg::COL_LAST, tccw_pkg::CH_NUL,
					            color_q, clr_last_q};
					state_d = clr_last_q ? tccw_pkg::ST_IDLE : tccw_pkg::ST_TAB;
				end
			end

			// A space per cycle; row-end runs close, waiting for ofree
			tccw_pkg::ST_TAB: begin
				if (adv.col_end) begin
					if (ofree) begin
						emit      = 1'b1;
						span      = '{tab_row, tab_first, ccol_q, tccw_pkg::CH_SPACE,
						              color_q, step_last && !adv.row_end};
						ccol_d    = adv.col_nx;
						crow_d    = adv.row_nx;
						open_d    = 1'b0;
						tab_cnt_d = tab_cnt_q + 1'b1;
						if (adv.row_end) begin
							wrap_d     = 1'b1;
							clr_last_d = step_last;
							state_d    = tccw_pkg::ST_WRAP_CLR;
						end else if (step_last) begin
							state_d = tccw_pkg::ST_IDLE;
						end
					end
				end else begin
					ccol_d      = adv.col_nx;
					open_d      = 1'b1;
					run_row_d   = tab_row;
					run_first_d = tab_first;
					run_last_d  = ccol_q;
					tab_cnt_d   = tab_cnt_q + 1'b1;
					if (step_last) begin
						state_d = tccw_pkg::ST_TAB_FLUSH;
					end
				end
			end

			tccw_pkg::ST_TAB_FLUSH: begin
				if (ofree) begin
					emit    = 1'b1;
					span    = '{run_row_q, run_first_q, run_last_q, tccw_pkg::CH_SPACE,
					            color_q, 1'b1};
					state_d = tccw_pkg::ST_IDLE;
				end
			end

			// Screen fill, one row per beat
			tccw_pkg::ST_FILL: begin
				adv_row = fill_row_q;
				if (ofree) begin
					emit       = 1'b1;
					span       = '{fill_row_q, '0, tccw_pkg::COL_LAST, tccw_pkg::CH_SPACE,
					               color_q, adv.row_end};
					fill_row_d = adv.row_nx;
					if (adv.row_end) begin
						state_d = tccw_pkg::ST_IDLE;
					end
				end
			end

			default: begin
				state_d = tccw_pkg::ST_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tccw_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Cursor, colour and sequencing control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q    <= tccw_pkg::DEFAULT_COLOR;
			crow_q     <= '0;
			ccol_q     <= '0;
			wrap_q     <= 1'b0;
			clr_last_q <= 1'b0;
			open_q     <= 1'b0;
			tab_cnt_q  <= '0;
			fill_row_q <= '0;
		end else begin
			color_q    <= color_d;
			crow_q     <= crow_d;
			ccol_q     <= ccol_d;
			wrap_q     <= wrap_d;
			clr_last_q <= clr_last_d;
			open_q     <= open_d;
			tab_cnt_q  <= tab_cnt_d;
			fill_row_q <= fill_row_d;
		end
	end

	// Payload held across the sequence
	always_ff @(posedge clk) begin
		ch_q        <= ch_d;
		run_row_q   <= run_row_d;
		run_first_q <= run_first_d;
		run_last_q  <= run_last_d;
	end

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> ofree)
		else $error("span issued while output stage full");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tccw_pkg::ST_IDLE) |-> !emit)
		else $error("span issued from idle");

	a_span_order: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (span.first_col <= span.last_col && span.row <= tccw_pkg::ROW_LAST))
		else $error("malformed span");

	a_wrap_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(wrap_q))
		else $error("wrapped flag dropped");

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(ccol_q <= tccw_pkg::COL_LAST) && (crow_q <= tccw_pkg::ROW_LAST))
		else $error("cursor off screen");

endmodule

// ===== src/text_console_cursor_writer_unit.sv =====
// Text console cursor writer.
// Input channel (in_valid / in_stall, fields mode and char_code) takes one
// command beat: put a character, clear the screen or initialise. Each command
// is turned into zero or more span beats on the output channel (out_valid /
// out_stall): fill row, columns first_column..last_column, with fill_char in
// fill_color; last marks the final span of a command.
// The colour register is written through cfg_valid / cfg_ready / text_color,
// only while no command is in progress.
// Timing: a command is taken from idle, then the sequencer takes one step
// per cycle and passes spans through a single output register, each visible
// the cycle after its step. A command keeps in_stall high until its last
// span has been issued; a newline without wrap is taken without leaving
// idle. A tab steps through its spaces and sends its last run from a flush
// step, or from its last step when that space lands in the last column,
// and clears row 0 when it wraps the screen. The shared row/column advance
// unit sets the rate. Once a span is held back in the output register by
// out_stall, the sequencer waits at its next span and in_stall stays high
// until the command has finished. Reset clears the cursor and wrapped flag
// and sets the colour to 7; no clearing pass is needed.
module text_console_cursor_writer_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [tccw_pkg::MODE_W-1:0]  mode,
	input  logic [tccw_pkg::CHAR_W-1:0]  char_code,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [tccw_pkg::COLOR_W-1:0] text_color,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [tccw_pkg::ROW_W-1:0]   row,
	output logic [tccw_pkg::COL_W-1:0]   first_column,
	output logic [tccw_pkg::COL_W-1:0]   last_column,
	output logic [tccw_pkg::CHAR_W-1:0]  fill_char,
	output logic [tccw_pkg::COLOR_W-1:0] fill_color,
	output logic                         last
);

	logic            ofree;
	logic            emit;
	logic            out_valid_q;
	tccw_pkg::span_t span;
	tccw_pkg::span_t span_q;

	tccw_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.mode      (mode),
		.char_code (char_code),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_color (text_color),
		.ofree     (ofree),
		.emit      (emit),
		.span      (span)
	);

	// Output stage: free when empty or being taken this cycle
	assign ofree = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ofree) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			span_q <= span;
		end
	end

	assign out_valid    = out_valid_q;
	assign row          = span_q.row;
	assign first_column = span_q.first_col;
	assign last_column  = span_q.last_col;
	assign fill_char    = span_q.ch;
	assign fill_color   = span_q.color;
	assign last         = span_q.last;

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

	// Mode 3 is not decoded by the block
	localparam logic [tccw_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam int LONG_HOLD = 300;

	typedef struct packed {
		logic [tccw_pkg::MODE_W-1:0] md;
		logic [tccw_pkg::CHAR_W-1:0] ch;
	} cmd_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	logic [tccw_pkg::MODE_W-1:0]   mode = '0;
	logic [tccw_pkg::CHAR_W-1:0]   char_code = '0;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [tccw_pkg::COLOR_W-1:0]  cfg_data = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic [tccw_pkg::ROW_W-1:0]    row;
	logic [tccw_pkg::COL_W-1:0]    first_column;
	logic [tccw_pkg::COL_W-1:0]    last_column;
	logic [tccw_pkg::CHAR_W-1:0]   fill_char;
	logic [tccw_pkg::COLOR_W-1:0]  fill_color;
	logic                          last;

	// Cursor and colour as the block should hold them
	logic [tccw_pkg::ROW_W-1:0]    cur_row = '0;
	logic [tccw_pkg::COL_W-1:0]    cur_col = '0;
	logic                          wrapped = 1'b0;
	logic [tccw_pkg::COLOR_W-1:0]  attr_reg = tccw_pkg::DEFAULT_COLOR;

	cmd_t            pending[$];
	tccw_pkg::span_t new_spans[$];
	tccw_pkg::span_t spans_due[$];
	cmd_t            next_cmd;

	int errors = 0;
	int items_taken = 0;
	int spans_seen = 0;
	int wraps_seen = 0;
	int tab_splits = 0;
	int screen_fills = 0;
	int burst_left = 4;
	int gap_left = 0;
	int hold_left = 0;
	int hold_mark = 60;
	logic [7:0] stall_tick = '0;

	text_console_cursor_writer_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.char_code    (char_code),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.text_color   (cfg_data),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.row          (row),
		.first_column (first_column),
		.last_column  (last_column),
		.fill_char    (fill_char),
		.fill_color   (fill_color),
		.last         (last)
	);

	always #4 clk = ~clk;

	// Span helpers for the cursor model
	function automatic void add_span(input logic [tccw_pkg::ROW_W-1:0] r,
		input logic [tccw_pkg::COL_W-1:0] f, input logic [tccw_pkg::COL_W-1:0] l,
		input logic [tccw_pkg::CHAR_W-1:0] c);
		tccw_pkg::span_t s;
		s.row       = r;
		s.first_col = f;
		s.last_col  = l;
		s.ch        = c;
		s.color     = attr_reg;
		s.last      = 1'b0;
		new_spans.push_back(s);
	endfunction

	// Next row; falling off the bottom returns to the top and blanks row 0
	function automatic void advance_row();
		if (cur_row == tccw_pkg::ROW_LAST) begin
			cur_row = '0;
			wrapped = 1'b1;
			wraps_seen++;
			add_span('0, '0, tccw_pkg::COL_LAST, tccw_pkg::CH_NUL);
		end else begin
			cur_row++;
		end
	endfunction

	function automatic void fill_all_rows();
		screen_fills++;
		for (int r = 0; r < tccw_pkg::SCREEN_HEIGHT; r++)
			add_span(tccw_pkg::ROW_W'(r), '0, tccw_pkg::COL_LAST, tccw_pkg::CH_SPACE);
	endfunction

	// Work out the spans one command beat produces and queue them
	function automatic void plan_spans(input logic [tccw_pkg::MODE_W-1:0] md,
		input logic [tccw_pkg::CHAR_W-1:0] ch);
		logic                       open;
		logic [tccw_pkg::ROW_W-1:0] run_row;
		logic [tccw_pkg::COL_W-1:0] run_first;
		logic [tccw_pkg::COL_W-1:0] run_last;
		tccw_pkg::span_t            tail;
		new_spans.delete();
		open      = 1'b0;
		run_row   = '0;
		run_first = '0;
		run_last  = '0;
		case (md)
			tccw_pkg::MODE_PUT: begin
				if (ch == tccw_pkg::CH_NEWLINE) begin
					cur_col = '0;
					advance_row();
				end else if (ch == tccw_pkg::CH_TAB) begin
					// spaces on one row merge; a row change closes the run first
					for (int t = 0; t < tccw_pkg::TAB_WIDTH; t++) begin
						if (!open) begin
							open      = 1'b1;
							run_row   = cur_row;
							run_first = cur_col;
						end
						run_last = cur_col;
						if (cur_col == tccw_pkg::COL_LAST) begin
							add_span(run_row, run_first, run_last, tccw_pkg::CH_SPACE);
							open    = 1'b0;
							cur_col = '0;
							tab_splits++;
							advance_row();
						end else begin
							cur_col++;
						end
					end
					if (open)
						add_span(run_row, run_first, run_last, tccw_pkg::CH_SPACE);
				end else begin
					// after a wrap the rest of the line is blanked first
					if (wrapped && cur_col != tccw_pkg::COL_LAST)
						add_span(cur_row, cur_col + 1'b1, tccw_pkg::COL_LAST, tccw_pkg::CH_NUL);
					add_span(cur_row, cur_col, cur_col, ch);
					if (cur_col == tccw_pkg::COL_LAST) begin
						cur_col = '0;
						advance_row();
					end else begin
						cur_col++;
					end
				end
			end
			tccw_pkg::MODE_CLEAR: fill_all_rows();
			tccw_pkg::MODE_INIT: begin
				attr_reg = tccw_pkg::DEFAULT_COLOR;
				cur_row  = '0;
				cur_col  = '0;
				fill_all_rows();
			end
			default: ;
		endcase
		if (new_spans.size() != 0) begin
			tail = new_spans.pop_back();
			tail.last = 1'b1;
			new_spans.push_back(tail);
		end
		foreach (new_spans[i])
			spans_due.push_back(new_spans[i]);
	endfunction

	function automatic void check_field(input string name, input logic [7:0] want,
		input logic [7:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endfunction

	// Command driver: bursts of beats with random gaps
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				plan_spans(mode, char_code);
				items_taken <= items_taken + 1;
			end
			if (!in_valid || !in_stall) begin
				if (gap_left != 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending.size() != 0) begin
					next_cmd = pending.pop_front();
					in_valid  <= 1'b1;
					mode      <= next_cmd.md;
					char_code <= next_cmd.ch;
					if (burst_left > 1) begin
						burst_left--;
					end else if ($urandom_range(0, 3) == 0) begin
						// back-to-back stretch
						burst_left = $urandom_range(30, 60);
						gap_left   = 0;
					end else begin
						burst_left = $urandom_range(1, 8);
						gap_left   = $urandom_range(1, 6);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off at fixed points of the command count
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (items_taken >= hold_mark) begin
			hold_left <= LONG_HOLD;
			hold_mark <= hold_mark + 110;
		end
	end

	// Span monitor and receiver stall pattern
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (spans_due.size() == 0) begin
					errors++;
					$display("%0t: unexpected span, expected nothing, actual row %0d cols %0d..%0d",
						$time, row, first_column, last_column);
				end else begin
					tccw_pkg::span_t want;
					want = spans_due.pop_front();
					check_field("row", 8'(want.row), 8'(row));
					check_field("first_column", 8'(want.first_col), 8'(first_column));
					check_field("last_column", 8'(want.last_col), 8'(last_column));
					check_field("fill_char", want.ch, fill_char);
					check_field("fill_color", want.color, fill_color);
					check_field("last", 8'(want.last), 8'(last));
					spans_seen++;
				end
			end
			stall_tick <= stall_tick + 1'b1;
			// four styles in turn, chosen by the top bits of stall_tick: none, light random, every third, heavy random
			if (hold_left != 0)
				out_stall <= 1'b1;
			else if (stall_tick[7:6] == 2'd0)
				out_stall <= 1'b0;
			else if (stall_tick[7:6] == 2'd1)
				out_stall <= ($urandom_range(0, 99) < 30);
			else if (stall_tick[7:6] == 2'd2)
				out_stall <= (stall_tick % 3 == 0);
			else
				out_stall <= ($urandom_range(0, 99) < 75);
		end
	end

	task automatic push_cmd(input logic [tccw_pkg::MODE_W-1:0] md,
		input logic [tccw_pkg::CHAR_W-1:0] ch);
		cmd_t c;
		c.md = md;
		c.ch = ch;
		pending.push_back(c);
	endtask

	// Text lines, tab runs across the row end, newline runs over the bottom, screen clears and random beats
	task automatic queue_random_cmds(input int n);
		int k;
		int len;
		int pick;
		k = 0;
		while (k < n) begin
			pick = $urandom_range(0, 99);
			if (pick < 35) begin
				len = $urandom_range(1, 10);
				for (int j = 0; j < len && k < n; j++) begin
					push_cmd(tccw_pkg::MODE_PUT, 8'($urandom_range(0, 255)));
					k++;
				end
				push_cmd(tccw_pkg::MODE_PUT, tccw_pkg::CH_NEWLINE);
				k++;
			end else if (pick < 60) begin
				len = $urandom_range(18, 32);
				for (int j = 0; j < len && k < n; j++) begin
					if ($urandom_range(0, 99) < 65)
						push_cmd(tccw_pkg::MODE_PUT, tccw_pkg::CH_TAB);
					else
						push_cmd(tccw_pkg::MODE_PUT, 8'($urandom_range(0, 255)));
					k++;
				end
			end else if (pick < 80) begin
				len = $urandom_range(6, 26);
				for (int j = 0; j < len && k < n; j++) begin
					push_cmd(tccw_pkg::MODE_PUT, tccw_pkg::CH_NEWLINE);
					k++;
				end
			end else if (pick < 88) begin
				push_cmd(($urandom_range(0, 1) != 0) ? tccw_pkg::MODE_CLEAR : tccw_pkg::MODE_INIT,
					8'($urandom_range(0, 255)));
				k++;
			end else begin
				len = $urandom_range(1, 4);
				for (int j = 0; j < len && k < n; j++) begin
					push_cmd(tccw_pkg::MODE_W'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
					k++;
				end
			end
		end
	endtask

	// Drain: all beats sent, all spans back, then a short quiet spell
	task automatic settle();
		while (pending.size() != 0 || in_valid)
			@(posedge clk);
		while (spans_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_color(input logic [tccw_pkg::COLOR_W-1:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		attr_reg = v;
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset colour, field extremes, every mode
		push_cmd(tccw_pkg::MODE_PUT, 8'h41);
		push_cmd(tccw_pkg::MODE_PUT, 8'h00);
		push_cmd(tccw_pkg::MODE_PUT, 8'hFF);
		push_cmd(tccw_pkg::MODE_PUT, tccw_pkg::CH_SPACE);
		push_cmd(tccw_pkg::MODE_PUT, tccw_pkg::CH_TAB);
		push_cmd(tccw_pkg::MODE_PUT, tccw_pkg::CH_NEWLINE);
		push_cmd(tccw_pkg::MODE_CLEAR, 8'hFF);
		push_cmd(MODE_UNUSED, 8'hFF);
		push_cmd(MODE_UNUSED, tccw_pkg::CH_NEWLINE);
		push_cmd(tccw_pkg::MODE_PUT, 8'h7F);
		push_cmd(tccw_pkg::MODE_INIT, 8'h00);
		push_cmd(tccw_pkg::MODE_PUT, 8'h80);
		settle();

		write_color(8'h00);
		queue_random_cmds(90);
		settle();

		write_color(8'hFF);
		queue_random_cmds(90);
		settle();

		write_color(tccw_pkg::COLOR_W'($urandom_range(1, 254)));
		queue_random_cmds(70);
		settle();

		$display("Ran %0d command beats over four colour settings; %0d span beats checked.",
			items_taken, spans_seen);
		$display("Bottom wraps %0d, tabs split at row end %0d, full-screen fills %0d.",
			wraps_seen, tab_splits, screen_fills);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Watchdog
	initial begin
		#(4_000_000);
		$display("Timed out with %0d span beats still due", spans_due.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule
